### design/crc64_byte_stream_engine_assert.svh
// Assertion macros for the CRC-64 engine
`ifndef CRC64_BYTE_STREAM_ENGINE_ASSERT_SVH
`define CRC64_BYTE_STREAM_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define CRC64_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("crc64 assertion failed");
`define CRC64_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("crc64 assertion failed");
`else
`define CRC64_ASSERT(label, clk, rst_n, prop)
`define CRC64_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### design/crc64_pkg.sv
package crc64_pkg;

    localparam logic [63:0] CRC_POLY = 64'h42F0E1EBA9EA3693;
    localparam logic [63:0] CRC_ONES = {64{1'b1}};

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_ZERO     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEGATE_FINAL  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_APPEND_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [63:0] crc_result;
        logic [63:0] message_length;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_APPEND,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic append_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic append_go;
        logic rest_last;
    } dp_status_t;

    // one byte through the MSB-first CRC register
    function automatic logic [63:0] crc_byte(input logic [63:0] crc_in,
                                             input logic [7:0]  data);
        logic [63:0] crc;
        crc = crc_in ^ {data, 56'd0};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[63])
                crc = {crc[62:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[62:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

### design/crc64_ctrl.sv
module crc64_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_eom,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  crc64_pkg::dp_status_t status,
    output crc64_pkg::dp_cmd_t    cmd
);

    crc64_pkg::ctrl_state_t state_reg;
    crc64_pkg::ctrl_state_t state_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crc64_pkg::ST_RUN:
            begin
                if (cmd.take && in_eom)
                    state_next = status.append_go ? crc64_pkg::ST_APPEND
                                                  : crc64_pkg::ST_EMIT;
            end
            crc64_pkg::ST_APPEND:
            begin
                if (status.rest_last)
                    state_next = crc64_pkg::ST_EMIT;
            end
            crc64_pkg::ST_EMIT:
            begin
                if (slot_free)
                    state_next = crc64_pkg::ST_RUN;
            end
            default:
            begin
                state_next = crc64_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        in_stall        = 1'b1;
        cmd.take        = 1'b0;
        cmd.append_step = 1'b0;
        cmd.emit        = 1'b0;
        case (state_reg)
            crc64_pkg::ST_RUN:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            crc64_pkg::ST_APPEND:
            begin
                cmd.append_step = 1'b1;
            end
            crc64_pkg::ST_EMIT:
            begin
                cmd.emit = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        out_valid_next = cmd.emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crc64_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### design/crc64_dp.sv
module crc64_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [crc64_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic                                  cfg_data,
    input  crc64_pkg::in_word_t                   in_word,
    input  crc64_pkg::dp_cmd_t                    cmd,
    output crc64_pkg::dp_status_t                 status,
    output crc64_pkg::out_word_t                  out_word
);

    logic        init_zero_reg;
    logic        init_zero_next;
    logic        negate_final_reg;
    logic        negate_final_next;
    logic        append_length_reg;
    logic        append_length_next;
    logic        open_reg;
    logic        open_next;

    logic [63:0] crc_reg;
    logic [63:0] crc_next;
    logic [63:0] total_reg;
    logic [63:0] total_next;
    logic [63:0] rest_reg;
    logic [63:0] rest_next;
    logic [63:0] out_crc_reg;
    logic [63:0] out_crc_next;
    logic [63:0] out_len_reg;
    logic [63:0] out_len_next;

    logic        live;
    logic [63:0] crc_base;
    logic [63:0] total_base;
    logic [63:0] crc_item;
    logic [63:0] total_item;
    logic [63:0] crc_final;

    always_comb
    begin
        init_zero_next     = init_zero_reg;
        negate_final_next  = negate_final_reg;
        append_length_next = append_length_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                crc64_pkg::CFG_INIT_ZERO:     init_zero_next     = cfg_data;
                crc64_pkg::CFG_NEGATE_FINAL:  negate_final_next  = cfg_data;
                crc64_pkg::CFG_APPEND_LENGTH: append_length_next = cfg_data;
                default:                      init_zero_next     = init_zero_reg;
            endcase
        end
    end

    assign live       = in_word.byte_valid || in_word.end_of_message;
    assign crc_base   = open_reg ? crc_reg :
                        (init_zero_reg ? 64'd0 : crc64_pkg::CRC_ONES);
    assign total_base = open_reg ? total_reg : 64'd0;
    assign total_item = total_base + {63'd0, in_word.byte_valid};
    assign crc_item   = in_word.byte_valid ?
                        crc64_pkg::crc_byte(crc_base, in_word.data_byte) : crc_base;
    assign crc_final  = negate_final_reg ? ~crc_reg : crc_reg;

    assign status.append_go = append_length_reg && (total_item != 64'd0);
    assign status.rest_last = (rest_reg[63:8] == 56'd0);

    always_comb
    begin
        open_next    = open_reg;
        crc_next     = crc_reg;
        total_next   = total_reg;
        rest_next    = rest_reg;
        out_crc_next = out_crc_reg;
        out_len_next = out_len_reg;
        if (cmd.take && live)
        begin
            open_next  = 1'b1;
            crc_next   = crc_item;
            total_next = total_item;
            rest_next  = total_item;
        end
        if (cmd.append_step)
        begin
            crc_next  = crc64_pkg::crc_byte(crc_reg, rest_reg[7:0]);
            rest_next = {8'd0, rest_reg[63:8]};
        end
        if (cmd.emit)
        begin
            open_next    = 1'b0;
            crc_next     = crc_final;
            out_crc_next = crc_final;
            out_len_next = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_zero_reg     <= 1'b0;
            negate_final_reg  <= 1'b0;
            append_length_reg <= 1'b0;
            open_reg          <= 1'b0;
        end
        else
        begin
            init_zero_reg     <= init_zero_next;
            negate_final_reg  <= negate_final_next;
            append_length_reg <= append_length_next;
            open_reg          <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg     <= crc_next;
        total_reg   <= total_next;
        rest_reg    <= rest_next;
        out_crc_reg <= out_crc_next;
        out_len_reg <= out_len_next;
    end

    assign out_word.crc_result     = out_crc_reg;
    assign out_word.message_length = out_len_reg;

endmodule

### design/crc64_byte_stream_engine.sv
// channel   handshake              payload
// in        in_valid / in_stall    in_word  (data_byte, byte_valid, end_of_message)
// out       out_valid / out_stall  out_word (crc_result, message_length)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (bit 0 kept)
//
// Byte and idle words are taken one per cycle while the input is not stalled.
// When length append is on, each significant length byte (0 to 8) of an end word
// goes through a byte CRC step, and then the result is loaded.
// The input stalls from an end word until its result is in the output register.
// A held result does not block byte words; a new result waits for the slot.
// Async active-low reset: config clears to 0, no message open, output empty.
`include "crc64_byte_stream_engine_assert.svh"

module crc64_byte_stream_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  crc64_pkg::in_word_t               in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output crc64_pkg::out_word_t              out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crc64_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                              cfg_data
);

    crc64_pkg::dp_cmd_t    cmd;
    crc64_pkg::dp_status_t status;
    logic                  cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    crc64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_eom    (in_word.end_of_message),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    crc64_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_word  (out_word)
    );

    `CRC64_ASSERT(a_emit_slot_free, clk, rst_n, cmd.emit |-> !(out_valid && out_stall))
    `CRC64_ASSERT(a_append_stalls, clk, rst_n, cmd.append_step |-> in_stall)
    `CRC64_ASSERT(a_eom_pauses, clk, rst_n, (cmd.take && in_word.end_of_message) |=> in_stall)
    `CRC64_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

### dv/crc64_byte_stream_engine_test.sv
module crc64_byte_stream_engine_test;

    localparam logic [crc64_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_WORDS   = 160;
    localparam int LONG_LEN      = 260;
    localparam int LONG_HOLD     = 300;
    localparam int FIRST_HOLD_AT = 30;
    localparam int NEXT_HOLD_AT  = 130;
    localparam int TIMEOUT_UNITS = 8_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    crc64_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    crc64_pkg::out_word_t out_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [crc64_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic cfg_data = 1'b0;

    // predictor state
    logic init_zero_q = 1'b0;
    logic negate_q = 1'b0;
    logic append_q = 1'b0;
    logic [63:0] run_crc = crc64_pkg::CRC_ONES;
    logic [63:0] run_len = '0;
    logic msg_open = 1'b0;

    crc64_pkg::in_word_t pending_words[$];
    crc64_pkg::out_word_t expected_digests[$];

    int words_pushed = 0;
    int words_counted = 0;
    int words_taken = 0;
    int results_seen = 0;
    int errors = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_left = 0;
    int hold_at = FIRST_HOLD_AT;
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;

    crc64_byte_stream_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] crc64_shift_byte(input logic [63:0] crc,
                                                     input logic [7:0] b);
        logic fb;
        int i;
        for (i = 7; i >= 0; i--)
        begin
            fb = crc[63] ^ b[i];
            crc = {crc[62:0], 1'b0};
            if (fb)
                crc = crc ^ crc64_pkg::CRC_POLY;
        end
        return crc;
    endfunction

    function automatic void track_word(input crc64_pkg::in_word_t w);
        crc64_pkg::out_word_t res;
        logic [63:0] rest;
        if (!w.byte_valid && !w.end_of_message)
            return;
        if (!msg_open)
        begin
            run_crc = init_zero_q ? 64'd0 : crc64_pkg::CRC_ONES;
            run_len = '0;
            msg_open = 1'b1;
        end
        if (w.byte_valid)
        begin
            run_crc = crc64_shift_byte(run_crc, w.data_byte);
            run_len = run_len + 64'd1;
        end
        if (w.end_of_message)
        begin
            res.crc_result = run_crc;
            if (append_q)
                for (rest = run_len; rest != 0; rest = rest >> 8)
                    res.crc_result = crc64_shift_byte(res.crc_result, rest[7:0]);
            if (negate_q)
                res.crc_result = ~res.crc_result;
            res.message_length = run_len;
            expected_digests.push_back(res);
            run_crc = res.crc_result;
            msg_open = 1'b0;
        end
    endfunction

    function automatic void check_digest(input crc64_pkg::out_word_t got);
        crc64_pkg::out_word_t want;
        if (expected_digests.size() == 0)
        begin
            $error("unexpected word: crc_result %h message_length %0d",
                   got.crc_result, got.message_length);
            errors++;
            return;
        end
        want = expected_digests.pop_front();
        if (got.crc_result !== want.crc_result)
        begin
            $error("crc_result expected %h actual %h", want.crc_result, got.crc_result);
            errors++;
        end
        if (got.message_length !== want.message_length)
        begin
            $error("message_length expected %0d actual %0d",
                   want.message_length, got.message_length);
            errors++;
        end
    endfunction

    function automatic int draw_wait(input bit enabled);
        if (!enabled)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                track_word(in_word);
                words_taken++;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    in_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    send_wait = draw_wait(send_idle_on);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_digest(out_word);
                results_seen++;
                recv_wait = draw_wait(recv_idle_on);
                if (results_seen == hold_at)
                begin
                    hold_left = LONG_HOLD;
                    hold_at = (hold_at == FIRST_HOLD_AT) ? NEXT_HOLD_AT : 0;
                end
            end
            else if (out_valid && recv_wait > 0)
                recv_wait--;
            if (hold_left > 0)
                hold_left--;
            out_stall <= (hold_left > 0) || (recv_wait > 0);
        end
    end

    function automatic void queue_word(input logic [7:0] d, input logic v, input logic e);
        crc64_pkg::in_word_t w;
        w.data_byte = d;
        w.byte_valid = v;
        w.end_of_message = e;
        pending_words.push_back(w);
        words_pushed++;
        if (v || e)
            words_counted++;
    endfunction

    function automatic void queue_message(input int len);
        int i;
        bit split;
        split = ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            queue_word(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split);
        end
        if (len == 0 || split)
            queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endfunction

    function automatic int draw_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 80)
            return $urandom_range(1, 12);
        return $urandom_range(13, 64);
    endfunction

    // leaves cfg_valid high; caller lowers it after the last write
    task automatic write_setting(input logic [crc64_pkg::CFG_INDEX_W-1:0] idx,
                                 input logic val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            crc64_pkg::CFG_INIT_ZERO:     init_zero_q = val;
            crc64_pkg::CFG_NEGATE_FINAL:  negate_q = val;
            crc64_pkg::CFG_APPEND_LENGTH: append_q = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic iz, input logic nf, input logic al);
        if ($urandom_range(0, 1))
            write_setting(CFG_UNUSED_INDEX, 1'($urandom_range(0, 1)));
        write_setting(crc64_pkg::CFG_INIT_ZERO, iz);
        write_setting(crc64_pkg::CFG_NEGATE_FINAL, nf);
        write_setting(crc64_pkg::CFG_APPEND_LENGTH, al);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (words_taken != words_pushed || expected_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [2:0] s;
        int p;
        int start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings(1'b0, 1'b0, 1'b0);
        queue_word(8'hFF, 1'b0, 1'b0);
        queue_word(8'h5A, 1'b0, 1'b1);
        queue_word(8'h00, 1'b1, 1'b1);
        queue_word(8'hFF, 1'b1, 1'b1);
        queue_word(8'h80, 1'b1, 1'b0);
        queue_word(8'h00, 1'b0, 1'b0);
        queue_word(8'h01, 1'b1, 1'b0);
        queue_word(8'h7F, 1'b1, 1'b1);
        queue_word(8'hA5, 1'b1, 1'b0);
        settle();

        // message left open: the new init value waits for the next message
        apply_settings(1'b1, 1'b1, 1'b1);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        queue_word(8'h3C, 1'b1, 1'b1);
        queue_word(8'h00, 1'b0, 1'b1);
        queue_word(8'h00, 1'b1, 1'b1);
        queue_word(8'hFF, 1'b1, 1'b0);
        queue_word(8'h55, 1'b1, 1'b0);
        queue_word(8'hAA, 1'b0, 1'b1);
        queue_word(8'hFF, 1'b1, 1'b0);
        queue_word(8'hC3, 1'b0, 1'b1);
        settle();

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: s = 3'b111;
                1: s = 3'b101;
                2: s = 3'b000;
                3: s = 3'b011;
                default: s = 3'($urandom_range(0, 7));
            endcase
            apply_settings(s[2], s[1], s[0]);
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            start = words_counted;
            if (p < 2)
                queue_message(LONG_LEN + $urandom_range(0, 20));
            while (words_counted - start < PHASE_WORDS)
                queue_message(draw_length());
            settle();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #TIMEOUT_UNITS;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
